[design/xee_pkg.sv]
// xee_pkg: shared types, character codes and lookup functions for the xml entity escaper
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package xee_pkg;

    // ascii codes used in escapes and references
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    // pending sequence store and raw reference list
    localparam int PEND_DEPTH = 5;
    localparam int RAW_DEPTH  = PEND_DEPTH + 1;

    // position of the semicolon in a raw byte reference
    localparam logic [3:0] RAW_LAST = 4'd5;

    // what follows the raw byte references of one request
    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_CHAR,
        TAIL_ENT,
        TAIL_CP
    } tail_t;

    // named entities
    typedef enum logic [2:0] {
        ENT_AMP,
        ENT_APOS,
        ENT_LT,
        ENT_GT,
        ENT_QUOT
    } ent_t;

    // everything one input request produces, handed to the emitter
    typedef struct packed {
        logic [RAW_DEPTH-1:0][7:0] raw;
        logic [2:0]                raw_cnt;
        tail_t                     tail;
        logic [7:0]                ch;
        ent_t                      ent;
        logic [30:0]               cp;
        logic [2:0]                top;
        logic                      last;
    } xee_job_t;

    // lowercase hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
            c = 8'h30 + {4'd0, nib};
        else
            c = 8'h57 + {4'd0, nib};
        return c;
    endfunction

    // sequence length announced by a lead byte, zero when not a lead byte
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        casez (b)
            8'b110?????: len = 3'd2;
            8'b1110????: len = 3'd3;
            8'b11110???: len = 3'd4;
            8'b111110??: len = 3'd5;
            8'b1111110?: len = 3'd6;
            default:     len = 3'd0;
        endcase
        return len;
    endfunction

    // position of the closing semicolon of an entity
    function automatic logic [3:0] entity_last(input ent_t e);
        logic [3:0] p;
        case (e)
            ENT_AMP:  p = 4'd4;
            ENT_APOS: p = 4'd5;
            ENT_LT:   p = 4'd3;
            ENT_GT:   p = 4'd3;
            ENT_QUOT: p = 4'd5;
            default:  p = 4'd0;
        endcase
        return p;
    endfunction

    // character at a given position of an entity
    function automatic logic [7:0] entity_char(input ent_t e, input logic [3:0] pos);
        logic [7:0] c;
        c = CH_SEMI;
        if (pos == 4'd0)
            c = CH_AMP;
        else if (pos != entity_last(e))
        begin
            case (e)
                ENT_AMP:
                begin
                    case (pos)
                        4'd1:    c = "a";
                        4'd2:    c = "m";
                        default: c = "p";
                    endcase
                end
                ENT_APOS:
                begin
                    case (pos)
                        4'd1:    c = "a";
                        4'd2:    c = "p";
                        4'd3:    c = "o";
                        default: c = "s";
                    endcase
                end
                ENT_LT:
                begin
                    case (pos)
                        4'd1:    c = "l";
                        default: c = "t";
                    endcase
                end
                ENT_GT:
                begin
                    case (pos)
                        4'd1:    c = "g";
                        default: c = "t";
                    endcase
                end
                ENT_QUOT:
                begin
                    case (pos)
                        4'd1:    c = "q";
                        4'd2:    c = "u";
                        4'd3:    c = "o";
                        default: c = "t";
                    endcase
                end
                default: c = CH_SEMI;
            endcase
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[design/xee_if.sv]
// xee_in_if and xee_out_if: valid/ready channels of the xml entity escaper
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface xee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface xee_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_last;
    logic       string_end;

    modport source (output valid, output out_char, output run_last, output string_end,
                    input ready);
    modport sink   (input valid, input out_char, input run_last, input string_end,
                    output ready);
endinterface

`default_nettype wire

[design/xee_step.sv]
// xee_step: utf-8 sequence tracking; turns each accepted byte into an output job
// depends on xee_pkg
`timescale 1ns / 1ps
`default_nettype none

module xee_step
    import xee_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    input  wire logic       last_byte,
    output xee_job_t        job
);

    logic [7:0]  pend_reg [PEND_DEPTH];
    logic [2:0]  pcnt_reg, pcnt_next;
    logic [2:0]  elen_reg, elen_next;
    logic [24:0] acc_reg, acc_next;
    logic        wr_en;
    logic [2:0]  wr_idx;

    logic        is_cont;
    logic        cont_done;
    logic [2:0]  len;
    logic [7:0]  lead_mask;
    logic [30:0] cp_val;
    logic [31:0] cp_word;
    logic [2:0]  cp_top;

    assign is_cont   = (in_byte[7:6] == 2'b10);
    assign cont_done = ({1'b0, pcnt_reg} + 4'd1) >= {1'b0, elen_reg};
    assign len       = lead_len(in_byte);
    assign lead_mask = 8'h7F >> len;
    assign cp_val    = {acc_reg, in_byte[5:0]};
    assign cp_word   = {1'b0, cp_val};

    // highest non-zero hex digit of the code point
    always_comb
    begin
        cp_top = 3'd0;
        for (int k = 1; k < 8; k++)
        begin
            if (cp_word[4*k +: 4] != 4'd0)
                cp_top = 3'(k);
        end
    end

    // job and next sequence state for the byte on the input
    always_comb
    begin
        for (int i = 0; i < PEND_DEPTH; i++)
            job.raw[i] = (3'(i) < pcnt_reg) ? pend_reg[i] : in_byte;
        job.raw[RAW_DEPTH-1] = in_byte;
        job.raw_cnt = 3'd0;
        job.tail    = TAIL_NONE;
        job.ch      = in_byte;
        job.ent     = ENT_AMP;
        job.cp      = cp_val;
        job.top     = cp_top;
        job.last    = last_byte;

        pcnt_next = pcnt_reg;
        elen_next = elen_reg;
        acc_next  = acc_reg;
        wr_en     = 1'b0;
        wr_idx    = pcnt_reg;

        if (pcnt_reg != 3'd0 && is_cont)
        begin
            if (cont_done)
            begin
                job.tail  = TAIL_CP;
                pcnt_next = 3'd0;
                elen_next = 3'd0;
            end
            else if (last_byte)
            begin
                // cut-off sequence, pending bytes and this one go out raw
                job.raw_cnt = pcnt_reg + 3'd1;
                pcnt_next   = 3'd0;
                elen_next   = 3'd0;
            end
            else
            begin
                wr_en     = 1'b1;
                pcnt_next = pcnt_reg + 3'd1;
                acc_next  = {acc_reg[18:0], in_byte[5:0]};
            end
        end
        else
        begin
            // broken sequence flushes pending bytes, then the byte is taken afresh
            job.raw_cnt = pcnt_reg;
            pcnt_next   = 3'd0;
            elen_next   = 3'd0;
            if (!in_byte[7])
            begin
                job.tail = TAIL_ENT;
                case (in_byte)
                    CH_AMP:  job.ent = ENT_AMP;
                    CH_APOS: job.ent = ENT_APOS;
                    CH_LT:   job.ent = ENT_LT;
                    CH_GT:   job.ent = ENT_GT;
                    CH_QUOT: job.ent = ENT_QUOT;
                    default: job.tail = TAIL_CHAR;
                endcase
            end
            else if (len == 3'd0 || last_byte)
            begin
                job.raw_cnt = pcnt_reg + 3'd1;
            end
            else
            begin
                wr_en     = 1'b1;
                wr_idx    = 3'd0;
                pcnt_next = 3'd1;
                elen_next = len;
                acc_next  = {17'd0, in_byte & lead_mask};
            end
        end
    end

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg <= 3'd0;
            elen_reg <= 3'd0;
        end
        else if (accept)
        begin
            pcnt_reg <= pcnt_next;
            elen_reg <= elen_next;
        end
    end

    // pending bytes and partial code point
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            acc_reg <= acc_next;
            if (wr_en)
                pend_reg[wr_idx] <= in_byte;
        end
    end

endmodule

`default_nettype wire

[design/xee_emit.sv]
// xee_emit: job register and character sequencer with registered output channel
// depends on xee_pkg and xee_out_if
`timescale 1ns / 1ps
`default_nettype none

module xee_emit
    import xee_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load,
    input  wire xee_job_t job,
    output logic          job_ready,
    xee_out_if.source     out_ch
);

    xee_job_t   job_reg;
    logic [3:0] pos_reg;
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       run_last_reg;
    logic       string_end_reg;

    logic       in_raw;
    logic       job_valid;
    logic       advance;
    logic       last_char;
    logic [3:0] tail_last;
    logic [7:0] gen_char;
    logic [31:0] cp_word;
    logic [3:0] didx;

    assign in_raw    = (job_reg.raw_cnt != 3'd0);
    assign job_valid = in_raw || (job_reg.tail != TAIL_NONE);
    assign advance   = job_valid && (!out_valid_reg || out_ch.ready);
    assign cp_word   = {1'b0, job_reg.cp};
    assign didx      = {1'b0, job_reg.top} + 4'd3 - pos_reg;

    // final position of the tail unit
    always_comb
    begin
        case (job_reg.tail)
            TAIL_ENT: tail_last = entity_last(job_reg.ent);
            TAIL_CP:  tail_last = {1'b0, job_reg.top} + 4'd4;
            default:  tail_last = 4'd0;
        endcase
    end

    assign last_char = in_raw ? (job_reg.raw_cnt == 3'd1 && job_reg.tail == TAIL_NONE
                                 && pos_reg == RAW_LAST)
                              : (pos_reg == tail_last);
    assign job_ready = !job_valid || (advance && last_char);

    // character at the current position
    always_comb
    begin
        gen_char = CH_SEMI;
        if (in_raw)
        begin
            case (pos_reg)
                4'd0:    gen_char = CH_AMP;
                4'd1:    gen_char = CH_HASH;
                4'd2:    gen_char = CH_X;
                4'd3:    gen_char = hex_char(job_reg.raw[0][7:4]);
                4'd4:    gen_char = hex_char(job_reg.raw[0][3:0]);
                default: gen_char = CH_SEMI;
            endcase
        end
        else
        begin
            case (job_reg.tail)
                TAIL_CHAR: gen_char = job_reg.ch;
                TAIL_ENT:  gen_char = entity_char(job_reg.ent, pos_reg);
                TAIL_CP:
                begin
                    if (pos_reg == 4'd0)
                        gen_char = CH_AMP;
                    else if (pos_reg == 4'd1)
                        gen_char = CH_HASH;
                    else if (pos_reg == 4'd2)
                        gen_char = CH_X;
                    else if (pos_reg == tail_last)
                        gen_char = CH_SEMI;
                    else
                        gen_char = hex_char(cp_word[{didx[2:0], 2'b00} +: 4]);
                end
                default: gen_char = CH_SEMI;
            endcase
        end
    end

    // job register and position counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_reg <= '0;
            pos_reg <= 4'd0;
        end
        else if (load)
        begin
            job_reg <= job;
            pos_reg <= 4'd0;
        end
        else if (advance)
        begin
            if (in_raw)
            begin
                if (pos_reg == RAW_LAST)
                begin
                    for (int i = 0; i < RAW_DEPTH - 1; i++)
                        job_reg.raw[i] <= job_reg.raw[i+1];
                    job_reg.raw_cnt <= job_reg.raw_cnt - 3'd1;
                    pos_reg <= 4'd0;
                end
                else
                begin
                    pos_reg <= pos_reg + 4'd1;
                end
            end
            else if (pos_reg == tail_last)
            begin
                job_reg.tail <= TAIL_NONE;
                pos_reg <= 4'd0;
            end
            else
            begin
                pos_reg <= pos_reg + 4'd1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_char_reg   <= gen_char;
            run_last_reg   <= last_char;
            string_end_reg <= last_char && job_reg.last;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_char   = out_char_reg;
    assign out_ch.run_last   = run_last_reg;
    assign out_ch.string_end = string_end_reg;

endmodule

`default_nettype wire

[design/xml_entity_escaper_core.sv]
// xml_entity_escaper_core: escapes a utf-8 byte stream into xml-safe text
// depends on xee_pkg, xee_if, xee_step and xee_emit
//
// usage:
//   in_ch carries one string byte per request with last_byte on the final byte.
//   out_ch carries one escaped character per request; run_last marks the last
//   character caused by an input byte, string_end the final character of a string.
//   a byte is taken when valid and ready are high at a rising edge of clk.
// a taken byte enters the job register, then each character the output register.
// throughput: a byte holds the input until its last character goes to the output
//   register, so plain text streams one byte per cycle while out_ch.ready is high;
//   a lead or continuation byte that yields nothing does not hold the input. the
//   character sequencer emits one character per cycle from the job register while
//   out_ch.ready is high.
// reset: rst_n low clears the pending utf-8 sequence, the job and the output.
// stall: when out_ch.ready is low the output register holds its character, the
//   sequencer waits and in_ch.ready drops once the job register is busy.
`timescale 1ns / 1ps
`default_nettype none

module xml_entity_escaper_core
    import xee_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    xee_in_if.sink    in_ch,
    xee_out_if.source out_ch
);

    xee_job_t job;
    logic     job_ready;
    logic     accept;

    // input request handshake
    assign in_ch.ready = job_ready;
    assign accept      = in_ch.valid && job_ready;

    xee_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_ch.in_byte),
        .last_byte (in_ch.last_byte),
        .job       (job)
    );

    xee_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .job       (job),
        .job_ready (job_ready),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire
